[hw/rtl/dfdb_pkg.sv]
`default_nettype none
//------------------------------------------------------------------------------
// Display frame digit builder package
// Shared widths, codes, command and status types, and the fixed per-position
// tables of the display frame.
//------------------------------------------------------------------------------
package dfdb_pkg;

    localparam int FRAME_POSITIONS_DEF = 14;
    localparam int POS_NIBBLE_W        = 4;

    localparam int OPCODE_W = 2;
    localparam int PRICE_W  = 20;
    localparam int VOLUME_W = 24;
    localparam int COUNT_W  = 44;

    localparam int CONV_W      = 44;
    localparam int CONV_DIGITS = 14;
    localparam int BCD_W       = 4 * CONV_DIGITS;

    localparam logic [PRICE_W-1:0] PRICE_RESET = 20'd42300;
    localparam logic [3:0]         BLANK_DIGIT = 4'hF;
    localparam logic [3:0]         MARK_L      = 4'hA;
    localparam logic [3:0]         NO_STRETCH  = 4'd8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUMP  = 2'd0,
        OP_DUMMY = 2'd1,
        OP_TOTAL = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CONVERT,
        S_UPDATE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                    capture;
        logic                    conv_start;
        logic                    store_write;
        logic                    emit_load;
        logic                    last;
        logic [POS_NIBBLE_W-1:0] emit_pos;
    } dfdb_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic out_free;
    } dfdb_status_t;

    function automatic logic [3:0] reset_digit_one(input logic [3:0] pos);
        case (pos)
            4'd0:    return 4'hF;
            4'd1:    return 4'hF;
            4'd2:    return 4'hF;
            4'd3:    return 4'h5;
            4'd4:    return 4'h8;
            4'd5:    return 4'h9;
            4'd6:    return 4'h5;
            4'd7:    return 4'h6;
            4'd8:    return 4'hF;
            4'd9:    return 4'h3;
            4'd10:   return 4'h0;
            4'd11:   return 4'h5;
            4'd12:   return 4'h0;
            4'd13:   return 4'h0;
            default: return BLANK_DIGIT;
        endcase
    endfunction

    function automatic logic [3:0] reset_digit_two(input logic [3:0] pos);
        case (pos)
            4'd0:    return 4'hF;
            4'd1:    return 4'hF;
            4'd2:    return 4'hF;
            4'd3:    return 4'hF;
            4'd4:    return 4'h1;
            4'd5:    return 4'h9;
            4'd6:    return 4'h3;
            4'd7:    return 4'h3;
            4'd8:    return 4'h1;
            4'd9:    return 4'hA;
            4'd10:   return 4'h1;
            4'd11:   return 4'hA;
            4'd12:   return 4'hF;
            4'd13:   return 4'hA;
            default: return BLANK_DIGIT;
        endcase
    endfunction

    function automatic logic [3:0] dummy_digit_one(input logic [3:0] pos);
        case (pos)
            4'd0:    return 4'hA;
            4'd8:    return 4'h1;
            4'd9:    return 4'h8;
            4'd10:   return 4'h3;
            4'd11:   return 4'h3;
            4'd12:   return 4'h1;
            4'd13:   return 4'h3;
            default: return BLANK_DIGIT;
        endcase
    endfunction

    function automatic logic [3:0] dummy_digit_two(input logic [3:0] pos);
        case (pos)
            4'd5:    return 4'h8;
            4'd6:    return 4'h0;
            4'd7:    return 4'h6;
            4'd11:   return 4'h1;
            default: return BLANK_DIGIT;
        endcase
    endfunction

    function automatic logic [3:0] stretch_bit_of(input logic [3:0] pos);
        case (pos)
            4'd3:    return 4'd3;
            4'd6:    return 4'd6;
            4'd8:    return 4'd5;
            default: return NO_STRETCH;
        endcase
    endfunction

    function automatic logic [5:0] stretch_time_of(input logic [3:0] pos);
        case (pos)
            4'd3:    return 6'd57;
            4'd6:    return 6'd57;
            4'd8:    return 6'd59;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [12:0] latch_time_of(input logic [3:0] pos);
        case (pos)
            4'd7:    return 13'd6436;
            4'd11:   return 13'd105;
            4'd13:   return 13'd634;
            default: return 13'd14;
        endcase
    endfunction

endpackage
`default_nettype wire

[hw/rtl/display_frame_digit_builder_unit.sv]
`default_nettype none
//------------------------------------------------------------------------------
// Display frame digit builder
// Builds the two-lane digit frame of a segment display from a pump, dummy or
// totalizer request and sends it out one position at a time.
//------------------------------------------------------------------------------
// Each accepted request yields FRAME_POSITIONS output items, one per display
// position in ascending order, the last marked by last_byte. The request is
// captured and the price product formed at the accepting edge. Then the
// converters are loaded, the 44-bit operand is converted to decimal at two
// bits a cycle, the digit store is updated and the items are emitted at one
// per cycle while the output side is ready. A new request is accepted in the
// cycle after the last item of the previous frame enters the output
// register, so the block takes the next request only once a frame is through,
// and a stalled output side holds it off longer. The unit price register may be
// written at any time while no request is in progress; the new price applies
// to the next pump request.
module display_frame_digit_builder_unit
    import dfdb_pkg::*;
#(
    parameter int FRAME_POSITIONS = FRAME_POSITIONS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [PRICE_W-1:0]  cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic [VOLUME_W-1:0] volume_milli,
    input  wire logic [COUNT_W-1:0]  totalizer_count,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               lane_one_byte,
    output logic [7:0]               lane_two_byte,
    output logic [3:0]               stretch_bit,
    output logic [5:0]               stretch_time,
    output logic [12:0]              latch_high_time,
    output logic                     last_byte
);

    dfdb_cmd_t    cmd;
    dfdb_status_t status;

    assign cfg_ready = 1'b1;

    dfdb_ctrl #(
        .FRAME_POSITIONS (FRAME_POSITIONS)
    ) u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dfdb_datapath #(
        .FRAME_POSITIONS (FRAME_POSITIONS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .volume_milli    (volume_milli),
        .totalizer_count (totalizer_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .lane_one_byte   (lane_one_byte),
        .lane_two_byte   (lane_two_byte),
        .stretch_bit     (stretch_bit),
        .stretch_time    (stretch_time),
        .latch_high_time (latch_high_time),
        .last_byte       (last_byte)
    );

    // Once a request is taken the block stays busy until its frame is out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a frame was in progress");

    // While idle, the only item that can still wait is the last of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && out_valid) |-> last_byte)
        else $error("idle with a frame only partly delivered");

    // The last item of a frame always sits at the final position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_byte) |->
            (lane_one_byte[3:0] == 4'(FRAME_POSITIONS - 1)))
        else $error("frame end marked at the wrong position");

endmodule
`default_nettype wire

[hw/rtl/dfdb_bcd_conv.sv]
`default_nettype none
//------------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-three conversion that takes two bits of the binary operand
// in each cycle and holds the decimal digits once it is done.
//------------------------------------------------------------------------------
module dfdb_bcd_conv
    import dfdb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CONV_W-1:0] value,
    output logic                   done,
    output logic [BCD_W-1:0]       bcd
);

    localparam int STEPS = CONV_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CONV_W-1:0] bin_reg;
    logic [BCD_W-1:0]  bcd_reg;

    logic [BCD_W-1:0]  adj_a;
    logic [BCD_W-1:0]  adj_b;
    logic [BCD_W-1:0]  bcd_mid;
    logic [BCD_W-1:0]  bcd_next;
    logic [CONV_W-1:0] bin_mid;
    logic [CONV_W-1:0] bin_next;

    function automatic logic [BCD_W-1:0] adjust(input logic [BCD_W-1:0] digits);
        logic [BCD_W-1:0] res;
        res = digits;
        for (int d = 0; d < CONV_DIGITS; d++) begin
            if (digits[4*d +: 4] >= 4'd5) begin
                res[4*d +: 4] = digits[4*d +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    always_comb
    begin
        adj_a    = adjust(bcd_reg);
        bcd_mid  = {adj_a[BCD_W-2:0], bin_reg[CONV_W-1]};
        bin_mid  = {bin_reg[CONV_W-2:0], 1'b0};
        adj_b    = adjust(bcd_mid);
        bcd_next = {adj_b[BCD_W-2:0], bin_mid[CONV_W-1]};
        bin_next = {bin_mid[CONV_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign done = !busy_reg;
    assign bcd  = bcd_reg;

endmodule
`default_nettype wire

[hw/rtl/dfdb_ctrl.sv]
`default_nettype none
//------------------------------------------------------------------------------
// Frame builder controller
// Sequences capture, decimal conversion, digit store update and the emission
// of one item per display position.
//------------------------------------------------------------------------------
module dfdb_ctrl
    import dfdb_pkg::*;
#(
    parameter int FRAME_POSITIONS = FRAME_POSITIONS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire dfdb_status_t status,
    output dfdb_cmd_t         cmd
);

    localparam int                POS_W    = $clog2(FRAME_POSITIONS);
    localparam logic [POS_W-1:0]  LAST_POS = POS_W'(FRAME_POSITIONS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.emit_pos = POS_NIBBLE_W'(pos_reg);
        cmd.last     = (pos_reg == LAST_POS);
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.conv_start = 1'b1;
                state_next     = S_CONVERT;
            end
            S_CONVERT:
            begin
                if (status.conv_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.store_write = 1'b1;
                pos_next        = '0;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (pos_reg == LAST_POS)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/dfdb_datapath.sv]
`default_nettype none
//------------------------------------------------------------------------------
// Frame builder datapath
// Holds the unit price, the captured request, the price product, three
// decimal converters, the two-lane digit store and the output register.
//------------------------------------------------------------------------------
module dfdb_datapath
    import dfdb_pkg::*;
#(
    parameter int FRAME_POSITIONS = FRAME_POSITIONS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dfdb_cmd_t           cmd,
    output dfdb_status_t             status,
    input  wire logic                cfg_valid,
    input  wire logic [PRICE_W-1:0]  cfg_data,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic [VOLUME_W-1:0] volume_milli,
    input  wire logic [COUNT_W-1:0]  totalizer_count,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               lane_one_byte,
    output logic [7:0]               lane_two_byte,
    output logic [3:0]               stretch_bit,
    output logic [5:0]               stretch_time,
    output logic [12:0]              latch_high_time,
    output logic                     last_byte
);

    localparam int POS_W = $clog2(FRAME_POSITIONS);

    logic [PRICE_W-1:0]  price_reg;
    opcode_t             opcode_reg;
    logic [VOLUME_W-1:0] volume_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [CONV_W-1:0]   product_reg;

    logic [CONV_W-1:0]   src_a;
    logic [BCD_W-1:0]    bcd_a;
    logic [BCD_W-1:0]    bcd_b;
    logic [BCD_W-1:0]    bcd_c;
    logic                done_a;
    logic                done_b;
    logic                done_c;

    logic [3:0]          lane_one_reg [FRAME_POSITIONS];
    logic [3:0]          lane_two_reg [FRAME_POSITIONS];
    logic [3:0]          lane_one_next [FRAME_POSITIONS];
    logic [3:0]          lane_two_next [FRAME_POSITIONS];

    logic                out_valid_reg;
    logic [7:0]          lane_one_byte_reg;
    logic [7:0]          lane_two_byte_reg;
    logic [3:0]          stretch_bit_reg;
    logic [5:0]          stretch_time_reg;
    logic [12:0]         latch_high_time_reg;
    logic                last_byte_reg;
    logic [POS_W-1:0]    rd_pos;

    // A digit shows blank once everything from it upward is zero, except
    // the lowest digit of a field, which always shows its value.
    function automatic logic [3:0] field_digit(input logic [BCD_W-1:0] digits,
                                               input int idx,
                                               input logic lowest);
        logic [BCD_W-1:0] upper;
        upper = digits >> (4 * idx);
        return (lowest || (upper != '0)) ? upper[3:0] : BLANK_DIGIT;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            price_reg <= PRICE_RESET;
        end
        else if (cfg_valid)
        begin
            price_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opcode_reg  <= opcode_t'(opcode);
            volume_reg  <= volume_milli;
            count_reg   <= totalizer_count;
            product_reg <= CONV_W'(volume_milli * price_reg);
        end
    end

    assign src_a = (opcode_reg == OP_TOTAL) ? count_reg : product_reg;

    dfdb_bcd_conv u_conv_a
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.conv_start),
        .value (src_a),
        .done  (done_a),
        .bcd   (bcd_a)
    );

    dfdb_bcd_conv u_conv_b
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.conv_start),
        .value (CONV_W'(price_reg)),
        .done  (done_b),
        .bcd   (bcd_b)
    );

    dfdb_bcd_conv u_conv_c
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.conv_start),
        .value (CONV_W'(volume_reg)),
        .done  (done_c),
        .bcd   (bcd_c)
    );

    always_comb
    begin
        for (int p = 0; p < FRAME_POSITIONS; p++)
        begin
            lane_one_next[p] = lane_one_reg[p];
            lane_two_next[p] = lane_two_reg[p];
        end
        if (cmd.store_write)
        begin
            case (opcode_reg)
                OP_PUMP:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        lane_one_next[7 - i] = field_digit(bcd_a, i + 3, i == 0);
                    end
                    for (int i = 0; i < 6; i++)
                    begin
                        lane_one_next[13 - i] = field_digit(bcd_b, i, i == 0);
                    end
                    for (int i = 0; i < 7; i++)
                    begin
                        lane_two_next[7 - i] = field_digit(bcd_c, i, i == 0);
                    end
                end
                OP_DUMMY:
                begin
                    for (int p = 0; p < 14; p++)
                    begin
                        lane_one_next[p] = dummy_digit_one(4'(p));
                        lane_two_next[p] = dummy_digit_two(4'(p));
                    end
                end
                OP_TOTAL:
                begin
                    lane_one_next[0] = MARK_L;
                    lane_one_next[1] = MARK_L;
                    for (int i = 0; i < 6; i++)
                    begin
                        lane_one_next[13 - i] = field_digit(bcd_a, i, i == 0);
                    end
                    for (int i = 0; i < 7; i++)
                    begin
                        lane_two_next[7 - i] = field_digit(bcd_a, i + 6, i == 0);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < FRAME_POSITIONS; p++)
            begin
                lane_one_reg[p] <= reset_digit_one(4'(p));
                lane_two_reg[p] <= reset_digit_two(4'(p));
            end
        end
        else
        begin
            for (int p = 0; p < FRAME_POSITIONS; p++)
            begin
                lane_one_reg[p] <= lane_one_next[p];
                lane_two_reg[p] <= lane_two_next[p];
            end
        end
    end

    assign rd_pos = cmd.emit_pos[POS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            lane_one_byte_reg   <= {lane_one_reg[rd_pos], cmd.emit_pos};
            lane_two_byte_reg   <= {lane_two_reg[rd_pos], cmd.emit_pos};
            stretch_bit_reg     <= stretch_bit_of(cmd.emit_pos);
            stretch_time_reg    <= stretch_time_of(cmd.emit_pos);
            latch_high_time_reg <= latch_time_of(cmd.emit_pos);
            last_byte_reg       <= cmd.last;
        end
    end

    assign status.conv_done = done_a && done_b && done_c;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign lane_one_byte   = lane_one_byte_reg;
    assign lane_two_byte   = lane_two_byte_reg;
    assign stretch_bit     = stretch_bit_reg;
    assign stretch_time    = stretch_time_reg;
    assign latch_high_time = latch_high_time_reg;
    assign last_byte       = last_byte_reg;

endmodule
`default_nettype wire
